// ===== design/rle_sprite_palette_decoder_defines.svh =====
// Assertion macros shared by the checker of the sprite decoder.
// Needs nothing but a clock and an active-low reset at the point of use.
`ifndef RLE_SPRITE_PALETTE_DECODER_DEFINES_SVH
`define RLE_SPRITE_PALETTE_DECODER_DEFINES_SVH

// Same-cycle implication, reset aborts the check.
`define RSP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, reset aborts the check.
`define RSP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/rsp_pkg.sv =====
// Shared types and constants of the run-length sprite decoder.
// No dependencies.
package rsp_pkg;

	localparam int MAX_DIM      = 1024;
	localparam int PALETTE_SIZE = 256;
	localparam int PAL_AW       = $clog2(PALETTE_SIZE);
	localparam int RGB_W        = 24;
	localparam int DIM_W        = 11;
	localparam int POS_W        = 22;
	localparam int COL_W        = 12;
	localparam int ADDR_W       = 20;
	localparam int COLOR_W      = 32;
	localparam int CFG_IDX_W    = 2;

	localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_COUNT  = 3'd1,
		PH_SKIP   = 3'd2,
		PH_SCOUNT = 3'd3,
		PH_INDEX  = 3'd4,
		PH_DONE   = 3'd5
	} phase_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WIDTH  = 2'd0,
		CFG_HEIGHT = 2'd1,
		CFG_ROTATE = 2'd2,
		CFG_LENGTH = 2'd3
	} cfg_reg_t;

endpackage

// ===== design/rsp_if.sv =====
// Handshake channels of the sprite decoder: byte/palette input, pixel output,
// register write. Depends on rsp_pkg.
interface rsp_in_if import rsp_pkg::*; ();
	logic       valid;
	logic       ready;
	logic       func;
	logic       first_byte;
	logic [7:0] data_byte;
	logic [7:0] pal_index;
	logic [5:0] red_six;
	logic [5:0] green_six;
	logic [5:0] blue_six;

	modport source (output valid, func, first_byte, data_byte, pal_index, red_six,
		green_six, blue_six, input ready);
	modport sink (input valid, func, first_byte, data_byte, pal_index, red_six,
		green_six, blue_six, output ready);
endinterface

interface rsp_out_if import rsp_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               pixel_valid;
	logic [ADDR_W-1:0]  pixel_address;
	logic [COLOR_W-1:0] pixel_color;
	logic               picture_done;

	modport source (output valid, pixel_valid, pixel_address, pixel_color, picture_done,
		input ready);
	modport sink (input valid, pixel_valid, pixel_address, pixel_color, picture_done,
		output ready);
endinterface

interface rsp_cfg_if import rsp_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [POS_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== design/rsp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rsp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== design/rle_sprite_palette_decoder.sv =====
// Run-length sprite decoder: one request per cycle while the input is not stalled.
// Stage 1 decodes the byte and reads the palette RAM; stage 2 is the output register.
// Throughput is one request per cycle; input stalls only while both stages are full
// and the output is held off.
// Reset clears decode state, configuration registers and valid bits; pipeline data and the palette RAM are not cleared.
module rle_sprite_palette_decoder import rsp_pkg::*; #(
	parameter int DIM_MAX = MAX_DIM
) (
	input  logic clk,
	input  logic arst_n,
	rsp_in_if.sink    byte_in,
	rsp_out_if.source pix_out,
	rsp_cfg_if.sink   cfg
);

	localparam logic [DIM_W-1:0] DIM_CAP =
		(DIM_MAX > 2047) ? {DIM_W{1'b1}} : DIM_W'(DIM_MAX);

	// configuration
	logic [DIM_W-1:0] width_q, height_q;
	logic             rotate_q;
	logic [POS_W-1:0] length_q;

	// decode state
	phase_t           phase_q;
	logic [POS_W-1:0] pos_q, row_start_q;
	logic [7:0]       row_cnt_q, solid_q;
	logic [DIM_W-1:0] row_q;
	logic [COL_W-1:0] col_q;

	// pipeline
	logic              res_valid_s1, pix_valid_s1, done_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic              res_valid_s2, pix_valid_s2, done_s2;
	logic [ADDR_W-1:0] addr_s2;
	logic [COLOR_W-1:0] color_s2;

	logic [RGB_W-1:0] pal_rdata;
	logic             in_acc, dec_acc, pal_wr, adv_s1;
	logic [DIM_W-1:0] w, h;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_W'(1);
			height_q <= DIM_W'(1);
			rotate_q <= 1'b0;
			length_q <= '0;
		end else if (cfg.valid) begin
			unique case (cfg_reg_t'(cfg.index))
				CFG_WIDTH:  width_q  <= cfg.data[DIM_W-1:0];
				CFG_HEIGHT: height_q <= cfg.data[DIM_W-1:0];
				CFG_ROTATE: rotate_q <= cfg.data[0];
				CFG_LENGTH: length_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// 0 counts as 1, oversize is capped
	assign w = (width_q == '0) ? DIM_W'(1) :
		((32'(width_q) > DIM_MAX) ? DIM_CAP : width_q);
	assign h = (height_q == '0) ? DIM_W'(1) :
		((32'(height_q) > DIM_MAX) ? DIM_CAP : height_q);

	assign adv_s1        = res_valid_s1 && (!res_valid_s2 || pix_out.ready);
	assign byte_in.ready = !res_valid_s1 || adv_s1;
	assign in_acc        = byte_in.valid && byte_in.ready;
	assign dec_acc       = in_acc && byte_in.func;
	assign pal_wr        = in_acc && !byte_in.func;

	rsp_ram #(
		.WIDTH(RGB_W),
		.DEPTH(PALETTE_SIZE)
	) u_palette (
		.clk  (clk),
		.we   (pal_wr),
		.waddr(byte_in.pal_index[PAL_AW-1:0]),
		.wdata({byte_in.red_six, 2'b00, byte_in.green_six, 2'b00, byte_in.blue_six, 2'b00}),
		.re   (dec_acc),
		.raddr(byte_in.data_byte[PAL_AW-1:0]),
		.rdata(pal_rdata)
	);

	// effective state: a first byte restarts the picture
	phase_t           ph_c;
	logic [POS_W-1:0] pos_c, rs_c;
	logic [7:0]       cnt_c, sol_c;
	logic [DIM_W-1:0] row_c;
	logic [COL_W-1:0] col_c;

	always_comb begin
		if (byte_in.first_byte) begin
			ph_c  = PH_COUNT;
			pos_c = '0;
			rs_c  = '0;
			cnt_c = '0;
			sol_c = '0;
			row_c = '0;
			col_c = '0;
		end else begin
			ph_c  = phase_q;
			pos_c = pos_q;
			rs_c  = row_start_q;
			cnt_c = row_cnt_q;
			sol_c = solid_q;
			row_c = row_q;
			col_c = col_q;
		end
	end

	// row ends on reaching the width or using up the row's byte count
	function automatic logic row_over(input logic [POS_W-1:0] p, input logic [COL_W-1:0] c,
			input logic [POS_W-1:0] rs, input logic [7:0] cnt, input logic [DIM_W-1:0] wd);
		logic [POS_W-1:0] used;
		used = p - rs;
		return (c >= COL_W'(wd)) || (used >= POS_W'(cnt));
	endfunction

	phase_t           ph_n;
	logic [POS_W-1:0] pos_n, rs_n, pos_inc;
	logic [7:0]       cnt_n, sol_n;
	logic [DIM_W-1:0] row_n, row_inc, row_inc2;
	logic [COL_W-1:0] col_n, col_sum, col_inc;
	logic             last_here, last_next, pv;
	logic [7:0]       b;

	always_comb begin
		b         = byte_in.data_byte;
		pos_inc   = pos_c + POS_W'(1);
		row_inc   = row_c + DIM_W'(1);
		row_inc2  = row_c + DIM_W'(2);
		col_sum   = col_c + COL_W'(b);
		col_inc   = col_c + COL_W'(1);
		last_here = ({1'b0, pos_c} + (POS_W+1)'(1)) >= {1'b0, length_q};
		last_next = ({1'b0, pos_inc} + (POS_W+1)'(1)) >= {1'b0, length_q};
		ph_n  = ph_c;
		pos_n = pos_c;
		rs_n  = rs_c;
		cnt_n = cnt_c;
		sol_n = sol_c;
		row_n = row_c;
		col_n = col_c;
		pv    = 1'b0;
		if (ph_c != PH_IDLE && ph_c != PH_DONE) begin
			if (pos_c >= length_q) begin
				ph_n = PH_DONE;
			end else begin
				unique case (ph_c)
					PH_COUNT: begin
						cnt_n = b;
						rs_n  = pos_c;
						pos_n = pos_inc;
						if (b != '0) begin
							col_n = '0;
							ph_n  = PH_SKIP;
						end else begin
							row_n = row_inc;
							ph_n  = (row_inc >= h) ? PH_DONE : PH_COUNT;
						end
					end
					PH_SKIP: begin
						col_n = col_sum;
						if (col_sum >= COL_W'(w)) begin
							// the skip byte doubles as the next row's count
							if (last_here) begin
								ph_n = PH_DONE;
							end else begin
								row_n = row_inc;
								if (row_inc >= h) begin
									ph_n = PH_DONE;
								end else begin
									cnt_n = b;
									rs_n  = pos_c;
									pos_n = pos_inc;
									if (b != '0) begin
										col_n = '0;
										ph_n  = PH_SKIP;
									end else begin
										row_n = row_inc2;
										ph_n  = (row_inc2 >= h) ? PH_DONE : PH_COUNT;
									end
								end
							end
						end else begin
							pos_n = pos_inc;
							ph_n  = PH_SCOUNT;
						end
					end
					PH_SCOUNT: begin
						sol_n = b;
						pos_n = pos_inc;
						if (b != '0) begin
							ph_n = PH_INDEX;
						end else if (row_over(pos_inc, col_c, rs_c, cnt_c, w)) begin
							if (last_next) begin
								ph_n = PH_DONE;
							end else begin
								row_n = row_inc;
								ph_n  = (row_inc >= h) ? PH_DONE : PH_COUNT;
							end
						end else begin
							ph_n = PH_SKIP;
						end
					end
					PH_INDEX: begin
						pv    = (col_c < COL_W'(w)) && (row_c < h);
						pos_n = pos_inc;
						col_n = col_inc;
						sol_n = sol_c - 8'd1;
						if (sol_n == '0) begin
							if (row_over(pos_inc, col_inc, rs_c, cnt_c, w)) begin
								if (last_next) begin
									ph_n = PH_DONE;
								end else begin
									row_n = row_inc;
									ph_n  = (row_inc >= h) ? PH_DONE : PH_COUNT;
								end
							end else begin
								ph_n = PH_SKIP;
							end
						end
					end
					default: ph_n = PH_DONE;
				endcase
			end
		end
	end

	// one multiply-add serves both address layouts
	logic [COL_W-1:0]         mul_a, add_t;
	logic [DIM_W-1:0]         mul_b;
	logic [COL_W+DIM_W-1:0]   prod;
	logic [ADDR_W-1:0]        addr_c;

	always_comb begin
		if (rotate_q) begin
			mul_a = col_c;
			mul_b = h;
			add_t = COL_W'(h - row_c - DIM_W'(1));
		end else begin
			mul_a = COL_W'(row_c);
			mul_b = w;
			add_t = col_c;
		end
		prod   = mul_a * mul_b;
		addr_c = ADDR_W'(prod + (COL_W+DIM_W)'(add_t));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			pos_q       <= '0;
			row_start_q <= '0;
			row_cnt_q   <= '0;
			row_q       <= '0;
			col_q       <= '0;
			solid_q     <= '0;
		end else if (dec_acc) begin
			phase_q     <= ph_n;
			pos_q       <= pos_n;
			row_start_q <= rs_n;
			row_cnt_q   <= cnt_n;
			row_q       <= row_n;
			col_q       <= col_n;
			solid_q     <= sol_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s1 <= 1'b0;
			res_valid_s2 <= 1'b0;
		end else begin
			if (dec_acc) begin
				res_valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				res_valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				res_valid_s2 <= 1'b1;
			end else if (pix_out.ready) begin
				res_valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (dec_acc) begin
			pix_valid_s1 <= pv;
			addr_s1      <= pv ? addr_c : '0;
			done_s1      <= (ph_n == PH_DONE);
		end
		if (adv_s1) begin
			pix_valid_s2 <= pix_valid_s1;
			addr_s2      <= addr_s1;
			color_s2     <= pix_valid_s1 ? {ALPHA_OPAQUE, pal_rdata} : '0;
			done_s2      <= done_s1;
		end
	end

	assign pix_out.valid         = res_valid_s2;
	assign pix_out.pixel_valid   = pix_valid_s2;
	assign pix_out.pixel_address = addr_s2;
	assign pix_out.pixel_color   = color_s2;
	assign pix_out.picture_done  = done_s2;

endmodule

// ===== design/rsp_checker.sv =====
// Port-level checks of the sprite decoder, bound to the top level.
// Depends on rsp_pkg and rle_sprite_palette_decoder_defines.svh.
`include "rle_sprite_palette_decoder_defines.svh"

module rsp_checker import rsp_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               in_func,
	input logic               out_valid,
	input logic               out_ready,
	input logic               out_pixel_valid,
	input logic [ADDR_W-1:0]  out_pixel_address,
	input logic [COLOR_W-1:0] out_pixel_color,
	input logic               out_picture_done
);

	// a stalled result holds
	`RSP_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(out_pixel_valid) && $stable(out_pixel_address) && $stable(out_pixel_color) && $stable(out_picture_done),
		"stalled result changed")

	// every accepted encoded byte is followed by a valid result
	`RSP_ASSERT_NOW(a_byte_result, clk, arst_n, in_valid && in_ready && in_func,
		##2 out_valid, "encoded byte produced no result")

	// input backs up only behind a stalled output
	`RSP_ASSERT_NOW(a_stall_cause, clk, arst_n, !in_ready,
		out_valid && !out_ready, "input stalled without output backpressure")

	// pixels are opaque
	`RSP_ASSERT_NOW(a_alpha, clk, arst_n, out_valid && out_pixel_valid,
		out_pixel_color[31:24] == ALPHA_OPAQUE, "pixel without opaque alpha")

endmodule

bind rle_sprite_palette_decoder rsp_checker u_rsp_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (byte_in.valid),
	.in_ready         (byte_in.ready),
	.in_func          (byte_in.func),
	.out_valid        (pix_out.valid),
	.out_ready        (pix_out.ready),
	.out_pixel_valid  (pix_out.pixel_valid),
	.out_pixel_address(pix_out.pixel_address),
	.out_pixel_color  (pix_out.pixel_color),
	.out_picture_done (pix_out.picture_done)
);
